// File: rtl/core/text_console_writer_defines.svh
// Assertion macros shared by the text console writer RTL.
// Each expects clk and rst_n (active low) in scope at the point of use.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define TCW_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define TCW_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/tcw_pkg.sv
// Shared types and constants for the text console writer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // Store geometry and put-char behavior
  localparam int SCREEN_CELLS = 2048;
  localparam int TAB_SPACES   = 4;
  localparam int LIN_W        = 14;   // linear cell index, holds 64 * 128
  localparam int MAX_COLS     = 128;
  localparam int MAX_ROWS     = 64;

  // Stream payload widths (whole bytes)
  localparam int IN_W  = 48;
  localparam int OUT_W = 64;

  // Register reset values
  localparam logic [7:0] COLS_RST = 8'd80;
  localparam logic [6:0] ROWS_RST = 7'd25;
  localparam logic [7:0] ATTR_RST = 8'd7;

  // Register indexes
  localparam logic [2:0] CFG_COLUMNS = 3'd0;
  localparam logic [2:0] CFG_ROWS    = 3'd1;
  localparam logic [2:0] CFG_ATTR    = 3'd2;
  localparam logic [2:0] CFG_CURS_EN = 3'd3;
  localparam logic [2:0] CFG_PRIMARY = 3'd4;

  // Control characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Request kinds
  typedef enum logic [2:0] {
    REQ_PUT   = 3'd0,
    REQ_SET   = 3'd1,
    REQ_CLEAR = 3'd2,
    REQ_BOX   = 3'd3,
    REQ_READ  = 3'd4
  } tcw_req_kind_t;

  // Effective configuration seen by the engine
  typedef struct packed {
    logic [7:0] ncols;    // 1..128
    logic [6:0] nrows;    // 1..64
    logic [7:0] attr;
    logic       show_en;  // cursor enable and primary display
  } tcw_cfg_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] char_code;
    logic [6:0] col;
    logic [5:0] row;
    logic [7:0] col_end;
    logic [6:0] row_end;
    logic [7:0] box_attr;
  } tcw_req_t;

  typedef struct packed {
    logic [7:0]  cursor_col;
    logic [5:0]  cursor_row;
    logic [12:0] cursor_addr;
    logic        cursor_show;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic [15:0] scroll_count;
  } tcw_res_t;

  // Cell store write port
  typedef struct packed {
    logic             en;
    logic [LIN_W-1:0] addr;
    logic [15:0]      data;
  } tcw_wr_t;

endpackage

`default_nettype wire

// File: rtl/core/tcw_cell_store.sv
// Screen cell store: one write port, one read port, registered read data.
// Depends on tcw_pkg. Indexes past the store drop writes and read as zero.
`timescale 1ns / 1ps
`default_nettype none

module tcw_cell_store (
  input  logic                      clk,
  input  tcw_pkg::tcw_wr_t          wr,
  input  logic [tcw_pkg::LIN_W-1:0] rd_addr,
  output logic [15:0]               rd_data
);
  import tcw_pkg::*;

  localparam int CELL_AW = $clog2(SCREEN_CELLS);

  logic [15:0] mem [SCREEN_CELLS];
  logic [15:0] q_r;
  logic        hit_r;
  logic        wr_hit;
  logic        rd_hit;

  assign wr_hit = (wr.addr < LIN_W'(SCREEN_CELLS));
  assign rd_hit = (rd_addr < LIN_W'(SCREEN_CELLS));

  // char in low byte, attribute in high byte
  always_ff @(posedge clk) begin
    if (wr.en && wr_hit) begin
      mem[wr.addr[CELL_AW-1:0]] <= wr.data;
    end
    q_r   <= mem[rd_addr[CELL_AW-1:0]];
    hit_r <= rd_hit;
  end

  assign rd_data = hit_r ? q_r : 16'h0000;

endmodule

`default_nettype wire

// File: rtl/core/tcw_engine.sv
// Request sequencer: cursor, scroll counter and walks over the cell store.
// Depends on tcw_pkg and text_console_writer_defines.svh; drives tcw_cell_store.
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_writer_defines.svh"

module tcw_engine (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tcw_pkg::tcw_cfg_t         cfg,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  tcw_pkg::tcw_req_t         req,
  output logic                      res_valid,
  input  logic                      res_ready,
  output tcw_pkg::tcw_res_t         res,
  output tcw_pkg::tcw_wr_t          mem_wr,
  output logic [tcw_pkg::LIN_W-1:0] mem_rd_addr,
  input  logic [15:0]               mem_rd_data
);
  import tcw_pkg::*;

  localparam int TAB_CW = (TAB_SPACES > 1) ? $clog2(TAB_SPACES) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_WRAP, S_PUT_MUL, S_PUT_ACT,
    S_SC_MUL, S_SC_PREP, S_SC_RUN, S_CLR_INIT, S_CLR_RUN,
    S_BOX_INIT, S_BOX_RUN, S_RD_ISSUE, S_RD_WAIT, S_FIN, S_RES
  } state_t;

  typedef enum logic [1:0] {WK_FILL, WK_COPY, WK_BOX} wkind_t;

  state_t            state_r, state_nxt;
  tcw_req_t          req_r, req_nxt;
  logic [7:0]        cur_col_r, cur_col_nxt;
  logic [5:0]        cur_row_r, cur_row_nxt;
  logic [15:0]       scroll_r, scroll_nxt;
  logic              moved_r, moved_nxt;
  logic [15:0]       cell_r, cell_nxt;
  logic [TAB_CW-1:0] tab_r, tab_nxt;
  logic              ret_put_r, ret_put_nxt;
  logic [LIN_W-1:0]  mul_r, mul_nxt;
  logic [LIN_W-1:0]  a_r, a_nxt;
  logic [LIN_W-1:0]  total_r, total_nxt;
  logic [LIN_W-1:0]  limit_r, limit_nxt;
  logic [LIN_W-1:0]  base_r, base_nxt;
  logic [7:0]        bcol_r, bcol_nxt;
  logic [6:0]        brow_r, brow_nxt;
  logic [7:0]        c1e_r, c1e_nxt;
  logic [6:0]        r1e_r, r1e_nxt;

  // write stage, the cycle after the read issue
  logic              p_valid_r, p_valid_nxt;
  wkind_t            p_kind_r, p_kind_nxt;
  logic [LIN_W-1:0]  p_addr_r, p_addr_nxt;
  logic [15:0]       p_fill_r, p_fill_nxt;

  logic [7:0]        nc;
  logic [6:0]        nr;
  logic [LIN_W-1:0]  nc_lin;
  logic [15:0]       blank;
  logic [6:0]        mul_a;
  logic [14:0]       mul_full;
  logic [6:0]        row_inc;
  logic [6:0]        last_row;
  logic              nl_scroll;
  logic              row_in_range;
  logic [LIN_W-1:0]  put_addr;
  logic [LIN_W-1:0]  a_inc;
  logic [7:0]        c0_ext;
  logic [6:0]        r0_ext;

  assign nc       = cfg.ncols;
  assign nr       = cfg.nrows;
  assign nc_lin   = LIN_W'(nc);
  assign blank    = {cfg.attr, CH_SPACE};
  assign mul_full = {8'b0, mul_a} * {7'b0, nc};
  assign mul_nxt  = mul_full[LIN_W-1:0];
  assign row_inc  = {1'b0, cur_row_r} + 7'd1;
  assign last_row = nr - 7'd1;
  assign nl_scroll    = (row_inc >= nr);
  assign row_in_range = ({1'b0, cur_row_r} < nr);
  assign put_addr = mul_r + LIN_W'(cur_col_r);
  assign a_inc    = a_r + LIN_W'(1);
  assign c0_ext   = {1'b0, req_r.col};
  assign r0_ext   = {1'b0, req_r.row};

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RES);

  // Result fields
  always_comb begin
    res.cursor_col   = cur_col_r;
    res.cursor_row   = cur_row_r;
    res.cursor_addr  = put_addr[12:0];
    res.cursor_show  = moved_r & cfg.show_en;
    res.cell_char    = cell_r[7:0];
    res.cell_attr    = cell_r[15:8];
    res.scroll_count = scroll_r;
  end

  // Write stage: merge read data for copy and attribute paint
  always_comb begin
    mem_wr.en   = p_valid_r;
    mem_wr.addr = p_addr_r;
    case (p_kind_r)
      WK_COPY: mem_wr.data = mem_rd_data;
      WK_BOX:  mem_wr.data = {req_r.box_attr, mem_rd_data[7:0]};
      default: mem_wr.data = p_fill_r;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    scroll_nxt  = scroll_r;
    moved_nxt   = moved_r;
    cell_nxt    = cell_r;
    tab_nxt     = tab_r;
    ret_put_nxt = ret_put_r;
    a_nxt       = a_r;
    total_nxt   = total_r;
    limit_nxt   = limit_r;
    base_nxt    = base_r;
    bcol_nxt    = bcol_r;
    brow_nxt    = brow_r;
    c1e_nxt     = c1e_r;
    r1e_nxt     = r1e_r;
    mul_a       = {1'b0, cur_row_r};
    mem_rd_addr = '0;
    p_valid_nxt = 1'b0;
    p_kind_nxt  = WK_FILL;
    p_addr_nxt  = '0;
    p_fill_nxt  = blank;

    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          req_nxt   = req;
          moved_nxt = 1'b0;
          cell_nxt  = 16'h0000;
          state_nxt = S_START;
        end
      end

      S_START: begin
        case (req_r.req_type)
          REQ_PUT: begin
            // cursor below the screen snaps to the last row, not a move
            if (!row_in_range) begin
              cur_row_nxt = last_row[5:0];
            end
            tab_nxt   = TAB_CW'(TAB_SPACES - 1);
            state_nxt = S_WRAP;
          end
          REQ_SET: begin
            cur_col_nxt = (c0_ext > nc) ? nc : c0_ext;
            cur_row_nxt = (r0_ext >= nr) ? last_row[5:0] : req_r.row;
            moved_nxt   = 1'b1;
            state_nxt   = S_FIN;
          end
          REQ_CLEAR: begin
            mul_a     = nr;
            state_nxt = S_CLR_INIT;
          end
          REQ_BOX: begin
            mul_a     = r0_ext;
            c1e_nxt   = (req_r.col_end > nc) ? nc : req_r.col_end;
            r1e_nxt   = (req_r.row_end > nr) ? nr : req_r.row_end;
            state_nxt = S_BOX_INIT;
          end
          REQ_READ: begin
            mul_a     = r0_ext;
            state_nxt = S_RD_ISSUE;
          end
          default: state_nxt = S_FIN;
        endcase
      end

      // pending wrap: next line, then back to the character
      S_WRAP: begin
        if (cur_col_r >= nc) begin
          if (nl_scroll) begin
            ret_put_nxt = 1'b1;
            state_nxt   = S_SC_MUL;
          end else begin
            cur_col_nxt = 8'd0;
            cur_row_nxt = row_inc[5:0];
            moved_nxt   = 1'b1;
            state_nxt   = S_PUT_MUL;
          end
        end else begin
          state_nxt = S_PUT_MUL;
        end
      end

      S_PUT_MUL: state_nxt = S_PUT_ACT;

      S_PUT_ACT: begin
        state_nxt = S_FIN;
        case (req_r.char_code)
          CH_TAB: begin
            p_valid_nxt = 1'b1;
            p_addr_nxt  = put_addr;
            cur_col_nxt = cur_col_r + 8'd1;
            moved_nxt   = 1'b1;
            if (tab_r != '0) begin
              tab_nxt   = tab_r - TAB_CW'(1);
              state_nxt = S_WRAP;
            end
          end
          CH_LF: begin
            if (nl_scroll) begin
              ret_put_nxt = 1'b0;
              state_nxt   = S_SC_MUL;
            end else begin
              cur_col_nxt = 8'd0;
              cur_row_nxt = row_inc[5:0];
              moved_nxt   = 1'b1;
            end
          end
          CH_BS: begin
            if (cur_col_r == 8'd0) begin
              // step back over the row end; nothing at home
              if (cur_row_r != 6'd0) begin
                p_valid_nxt = 1'b1;
                p_addr_nxt  = mul_r - LIN_W'(1);
                cur_col_nxt = nc - 8'd1;
                cur_row_nxt = cur_row_r - 6'd1;
                moved_nxt   = 1'b1;
              end
            end else begin
              p_valid_nxt = 1'b1;
              p_addr_nxt  = put_addr - LIN_W'(1);
              cur_col_nxt = cur_col_r - 8'd1;
              moved_nxt   = 1'b1;
            end
          end
          CH_NUL, CH_CR: ;
          default: begin
            p_valid_nxt = 1'b1;
            p_addr_nxt  = put_addr;
            p_fill_nxt  = {cfg.attr, req_r.char_code};
            cur_col_nxt = cur_col_r + 8'd1;
            moved_nxt   = 1'b1;
          end
        endcase
      end

      // scroll: copy cell a+cols down to a, then blank the last row
      S_SC_MUL: begin
        mul_a     = nr;
        state_nxt = S_SC_PREP;
      end

      S_SC_PREP: begin
        total_nxt = mul_r;
        limit_nxt = mul_r - nc_lin;
        a_nxt     = '0;
        state_nxt = S_SC_RUN;
      end

      S_SC_RUN: begin
        p_valid_nxt = 1'b1;
        p_addr_nxt  = a_r;
        if (a_r < limit_r) begin
          mem_rd_addr = a_r + nc_lin;
          p_kind_nxt  = WK_COPY;
        end
        a_nxt = a_inc;
        if (a_inc == total_r) begin
          cur_col_nxt = 8'd0;
          cur_row_nxt = last_row[5:0];
          scroll_nxt  = scroll_r + 16'd1;
          moved_nxt   = 1'b1;
          state_nxt   = ret_put_r ? S_PUT_MUL : S_FIN;
        end
      end

      S_CLR_INIT: begin
        total_nxt = mul_r;
        a_nxt     = '0;
        state_nxt = S_CLR_RUN;
      end

      S_CLR_RUN: begin
        p_valid_nxt = 1'b1;
        p_addr_nxt  = a_r;
        a_nxt       = a_inc;
        if (a_inc == total_r) begin
          cur_col_nxt = 8'd0;
          cur_row_nxt = 6'd0;
          scroll_nxt  = 16'd0;
          moved_nxt   = 1'b1;
          state_nxt   = S_FIN;
        end
      end

      S_BOX_INIT: begin
        base_nxt = mul_r;
        bcol_nxt = c0_ext;
        brow_nxt = r0_ext;
        if ((c0_ext >= c1e_r) || (r0_ext >= r1e_r)) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_BOX_RUN;
        end
      end

      // one cell a cycle: read here, merged write next cycle
      S_BOX_RUN: begin
        mem_rd_addr = base_r + LIN_W'(bcol_r);
        p_valid_nxt = 1'b1;
        p_kind_nxt  = WK_BOX;
        p_addr_nxt  = base_r + LIN_W'(bcol_r);
        if ((bcol_r + 8'd1) == c1e_r) begin
          bcol_nxt = c0_ext;
          brow_nxt = brow_r + 7'd1;
          base_nxt = base_r + nc_lin;
          if ((brow_r + 7'd1) == r1e_r) begin
            state_nxt = S_FIN;
          end
        end else begin
          bcol_nxt = bcol_r + 8'd1;
        end
      end

      S_RD_ISSUE: begin
        if ((c0_ext < nc) && (r0_ext < nr)) begin
          mem_rd_addr = mul_r + LIN_W'(req_r.col);
          state_nxt   = S_RD_WAIT;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_RD_WAIT: begin
        cell_nxt  = mem_rd_data;
        state_nxt = S_FIN;
      end

      // product of cursor row and columns lands for the result
      S_FIN: state_nxt = S_RES;

      S_RES: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    cell_r    <= cell_nxt;
    tab_r     <= tab_nxt;
    ret_put_r <= ret_put_nxt;
    mul_r     <= mul_nxt;
    a_r       <= a_nxt;
    total_r   <= total_nxt;
    limit_r   <= limit_nxt;
    base_r    <= base_nxt;
    bcol_r    <= bcol_nxt;
    brow_r    <= brow_nxt;
    c1e_r     <= c1e_nxt;
    r1e_r     <= r1e_nxt;
    p_kind_r  <= p_kind_nxt;
    p_addr_r  <= p_addr_nxt;
    p_fill_r  <= p_fill_nxt;
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cur_col_r <= 8'd0;
      cur_row_r <= 6'd0;
      scroll_r  <= 16'd0;
      moved_r   <= 1'b0;
      p_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      scroll_r  <= scroll_nxt;
      moved_r   <= moved_nxt;
      p_valid_r <= p_valid_nxt;
    end
  end

  // Checks
  `TCW_CHECK_NEXT(a_accept_starts, req_valid && req_ready, state_r == S_START, "accepted beat did not start a request")
  `TCW_CHECK(a_idle_no_write, state_r == S_IDLE, !p_valid_r, "cell write still pending while idle")
  `TCW_CHECK(a_put_row_on_screen, state_r == S_RES && req_r.req_type == REQ_PUT, row_in_range, "put char left the cursor below the screen")
  `TCW_CHECK_NEXT(a_idle_scroll_hold, state_r == S_IDLE, $stable(scroll_r), "scroll count moved while idle")

endmodule

`default_nettype wire

// File: rtl/core/text_console_writer.sv
// Throughput: one request at a time, next beat taken the cycle after the result leaves the
// engine; all walks move one store cell per cycle through the single write port.
// Reset (rst_n, synchronous): cursor 0,0, scroll count 0, registers to defaults; store not cleared.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer (
  input  logic                      clk,
  input  logic                      rst_n,
  // in_tdata: char_code[7:0] col[14:8] row[20:15] col_end[28:21] row_end[35:29]
  //           box_attr[43:36], zero[47:44]
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [tcw_pkg::IN_W-1:0]  in_tdata,
  // in_tuser: req_type[2:0]
  input  logic [2:0]                in_tuser,
  // out_tdata: cursor_col[7:0] cursor_row[13:8] cursor_addr[26:14] cursor_show[27]
  //            cell_char[35:28] cell_attr[43:36] scroll_count[59:44], zero[63:60]
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [tcw_pkg::OUT_W-1:0] out_tdata,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [2:0]                cfg_addr,
  input  logic [7:0]                cfg_data
);
  import tcw_pkg::*;

  logic [7:0]       columns_r;
  logic [6:0]       rows_r;
  logic [7:0]       attr_r;
  logic             curs_en_r;
  logic             primary_r;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  tcw_cfg_t         cfg;
  tcw_req_t         req;
  tcw_res_t         res;
  tcw_wr_t          mem_wr;
  logic [LIN_W-1:0] mem_rd_addr;
  logic [15:0]      mem_rd_data;
  logic             res_valid;
  logic             res_ready;

  // Register writes, always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= COLS_RST;
      rows_r    <= ROWS_RST;
      attr_r    <= ATTR_RST;
      curs_en_r <= 1'b1;
      primary_r <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_addr)
        CFG_COLUMNS: columns_r <= cfg_data;
        CFG_ROWS:    rows_r    <= cfg_data[6:0];
        CFG_ATTR:    attr_r    <= cfg_data;
        CFG_CURS_EN: curs_en_r <= cfg_data[0];
        CFG_PRIMARY: primary_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp geometry to the supported range
  always_comb begin
    if (columns_r == 8'd0) begin
      cfg.ncols = 8'd1;
    end else if (columns_r > 8'(MAX_COLS)) begin
      cfg.ncols = 8'(MAX_COLS);
    end else begin
      cfg.ncols = columns_r;
    end
    if (rows_r == 7'd0) begin
      cfg.nrows = 7'd1;
    end else if (rows_r > 7'(MAX_ROWS)) begin
      cfg.nrows = 7'(MAX_ROWS);
    end else begin
      cfg.nrows = rows_r;
    end
    cfg.attr    = attr_r;
    cfg.show_en = curs_en_r & primary_r;
  end

  // Input beat unpack
  always_comb begin
    req.req_type  = in_tuser;
    req.char_code = in_tdata[7:0];
    req.col       = in_tdata[14:8];
    req.row       = in_tdata[20:15];
    req.col_end   = in_tdata[28:21];
    req.row_end   = in_tdata[35:29];
    req.box_attr  = in_tdata[43:36];
  end

  tcw_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .req_valid   (in_tvalid),
    .req_ready   (in_tready),
    .req         (req),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_wr      (mem_wr),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  tcw_cell_store u_store (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Output register: holds one result beat
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {4'b0000, res.scroll_count, res.cell_attr, res.cell_char,
                       res.cursor_show, res.cursor_addr, res.cursor_row, res.cursor_col};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
